/* src/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg: shared definitions of the ADPCM stream decoder
// Field widths, register indexes, the step table and the index adjust table.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned StepW   = 15;
  localparam int unsigned DeltaW  = 18;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [IdxW-1:0] IdxReset = 7'h2C;
  localparam logic [IdxW-1:0] IdxMax   = 7'h58;

  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgShiftAmount  = 2'd0,
    CfgStereoMode   = 2'd1,
    CfgInitialLeft  = 2'd2,
    CfgInitialRight = 2'd3
  } cfg_reg_e;

  // control codes that repeat the last sample or raise the step index
  localparam logic [6:0] OpRepeat = 7'h00;
  localparam logic [6:0] OpRaise  = 7'h01;

  function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] s;
    unique case (idx)
      7'd0:  s = 15'h0007; 7'd1:  s = 15'h0008; 7'd2:  s = 15'h0009; 7'd3:  s = 15'h000A;
      7'd4:  s = 15'h000B; 7'd5:  s = 15'h000C; 7'd6:  s = 15'h000D; 7'd7:  s = 15'h000E;
      7'd8:  s = 15'h0010; 7'd9:  s = 15'h0011; 7'd10: s = 15'h0013; 7'd11: s = 15'h0015;
      7'd12: s = 15'h0017; 7'd13: s = 15'h0019; 7'd14: s = 15'h001C; 7'd15: s = 15'h001F;
      7'd16: s = 15'h0022; 7'd17: s = 15'h0025; 7'd18: s = 15'h0029; 7'd19: s = 15'h002D;
      7'd20: s = 15'h0032; 7'd21: s = 15'h0037; 7'd22: s = 15'h003C; 7'd23: s = 15'h0042;
      7'd24: s = 15'h0049; 7'd25: s = 15'h0050; 7'd26: s = 15'h0058; 7'd27: s = 15'h0061;
      7'd28: s = 15'h006B; 7'd29: s = 15'h0076; 7'd30: s = 15'h0082; 7'd31: s = 15'h008F;
      7'd32: s = 15'h009D; 7'd33: s = 15'h00AD; 7'd34: s = 15'h00BE; 7'd35: s = 15'h00D1;
      7'd36: s = 15'h00E6; 7'd37: s = 15'h00FD; 7'd38: s = 15'h0117; 7'd39: s = 15'h0133;
      7'd40: s = 15'h0151; 7'd41: s = 15'h0173; 7'd42: s = 15'h0198; 7'd43: s = 15'h01C1;
      7'd44: s = 15'h01EE; 7'd45: s = 15'h0220; 7'd46: s = 15'h0256; 7'd47: s = 15'h0292;
      7'd48: s = 15'h02D4; 7'd49: s = 15'h031C; 7'd50: s = 15'h036C; 7'd51: s = 15'h03C3;
      7'd52: s = 15'h0424; 7'd53: s = 15'h048E; 7'd54: s = 15'h0502; 7'd55: s = 15'h0583;
      7'd56: s = 15'h0610; 7'd57: s = 15'h06AB; 7'd58: s = 15'h0756; 7'd59: s = 15'h0812;
      7'd60: s = 15'h08E0; 7'd61: s = 15'h09C3; 7'd62: s = 15'h0ABD; 7'd63: s = 15'h0BD0;
      7'd64: s = 15'h0CFF; 7'd65: s = 15'h0E4C; 7'd66: s = 15'h0FBA; 7'd67: s = 15'h114C;
      7'd68: s = 15'h1307; 7'd69: s = 15'h14EE; 7'd70: s = 15'h1706; 7'd71: s = 15'h1954;
      7'd72: s = 15'h1BDC; 7'd73: s = 15'h1EA5; 7'd74: s = 15'h21B6; 7'd75: s = 15'h2515;
      7'd76: s = 15'h28CA; 7'd77: s = 15'h2CDF; 7'd78: s = 15'h315B; 7'd79: s = 15'h364B;
      7'd80: s = 15'h3BB9; 7'd81: s = 15'h41B2; 7'd82: s = 15'h4844; 7'd83: s = 15'h4F7E;
      7'd84: s = 15'h5771; 7'd85: s = 15'h602F; 7'd86: s = 15'h69CE; 7'd87: s = 15'h7462;
      7'd88: s = 15'h7FFF;
      default: s = '0;
    endcase
    return s;
  endfunction

  // index adjust for the low five code bits: -1 on every even code
  function automatic logic signed [4:0] index_adjust(input logic [4:0] code);
    logic signed [4:0] a;
    if (!code[0]) begin
      a = -5'sd1;
    end else begin
      unique case (code[4:1])
        4'd0:  a = 5'sd0; 4'd1:  a = 5'sd4; 4'd2:  a = 5'sd2; 4'd3:  a = 5'sd6;
        4'd4:  a = 5'sd1; 4'd5:  a = 5'sd5; 4'd6:  a = 5'sd3; 4'd7:  a = 5'sd7;
        4'd8:  a = 5'sd1; 4'd9:  a = 5'sd5; 4'd10: a = 5'sd3; 4'd11: a = 5'sd7;
        4'd12: a = 5'sd2; 4'd13: a = 5'sd4; 4'd14: a = 5'sd6; 4'd15: a = 5'sd8;
        default: a = 5'sd0;
      endcase
    end
    return a;
  endfunction

endpackage

/* src/adpcm_stream_decoder.sv */
// ----------------------------------------------------------------------------
// adpcm_stream_decoder
// Decodes a mono or stereo ADPCM byte stream into signed 16-bit samples.
// ----------------------------------------------------------------------------
// One compressed byte is accepted every clock cycle while the output is not
// stalled. A taken byte sits in the input register and its sample is loaded
// into the result register once that register is free or being read; the
// sample is then valid on the master side. The one-byte-per-cycle rate is
// set by the per-channel predictor and step index feedback: table lookup,
// shifted sum, saturating add and index clamp all complete combinationally
// between the input register and the state registers. Control codes that emit
// nothing produce no request on the master side. Load the header (shift,
// stereo mode, initial samples) through the configuration port while the
// decoder is idle, then send the first byte with tuser set to reload the
// channel state.

module adpcm_stream_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [asd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [asd_pkg::CfgW-1:0]            cfg_data_i,
  // compressed bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [asd_pkg::CodeW-1:0]           s_axis_tdata,   // [7:0] code_byte
  input  logic                                s_axis_tuser,   // [0] start_of_stream
  // decoded samples
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [asd_pkg::SampleW-1:0]         m_axis_tdata,   // [15:0] sample
  output logic                                m_axis_tuser    // [0] channel_id
);

  // configuration registers
  logic [7:0]                          shift_q;
  logic                                stereo_q;
  logic signed [asd_pkg::SampleW-1:0]  init_q [2];

  // input register
  logic                                in_vld_q;
  logic [asd_pkg::CodeW-1:0]           in_code_q;
  logic                                in_sos_q;

  // channel state
  logic [asd_pkg::IdxW-1:0]            idx_q   [2];
  logic [asd_pkg::IdxW-1:0]            idx_d   [2];
  logic signed [asd_pkg::SampleW-1:0]  pred_q  [2];
  logic signed [asd_pkg::SampleW-1:0]  pred_d  [2];
  logic                                chan_q, chan_d;

  // result register
  logic                                out_vld_q, out_vld_d;
  logic signed [asd_pkg::SampleW-1:0]  out_smp_q;
  logic                                out_ch_q;

  // datapath
  logic [asd_pkg::IdxW-1:0]            eff_idx  [2];
  logic signed [asd_pkg::SampleW-1:0]  eff_pred [2];
  logic                                eff_chan;
  logic                                ch;
  logic [asd_pkg::IdxW-1:0]            cur_idx;
  logic signed [asd_pkg::SampleW-1:0]  cur_pred;
  logic                                is_ctrl;
  logic [6:0]                          op;
  logic                                emit;
  logic                                advance;
  logic [asd_pkg::StepW-1:0]           step;
  logic [asd_pkg::DeltaW-1:0]          delta;
  logic signed [asd_pkg::DeltaW:0]     psum;
  logic signed [asd_pkg::SampleW-1:0]  new_pred;
  logic signed [8:0]                   idx_sum;
  logic signed [4:0]                   adj;
  logic [asd_pkg::IdxW-1:0]            new_idx;
  logic signed [asd_pkg::SampleW-1:0]  res_smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      stereo_q  <= 1'b0;
      init_q[0] <= '0;
      init_q[1] <= '0;
    end else if (cfg_we_i) begin
      unique case (asd_pkg::cfg_reg_e'(cfg_idx_i))
        asd_pkg::CfgShiftAmount:  shift_q   <= cfg_data_i[7:0];
        asd_pkg::CfgStereoMode:   stereo_q  <= cfg_data_i[0];
        asd_pkg::CfgInitialLeft:  init_q[0] <= cfg_data_i;
        asd_pkg::CfgInitialRight: init_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // decode of the registered byte
  // -------------------------------------------------------------------------
  always_comb begin
    // reload on start of stream
    for (int c = 0; c < 2; c++) begin
      eff_idx[c]  = in_sos_q ? asd_pkg::IdxReset : idx_q[c];
      eff_pred[c] = in_sos_q ? init_q[c] : pred_q[c];
    end
    eff_chan = in_sos_q ? stereo_q : chan_q;
    ch       = stereo_q ? ~eff_chan : eff_chan;
    cur_idx  = eff_idx[ch];
    cur_pred = eff_pred[ch];

    is_ctrl = in_code_q[7];
    op      = in_code_q[6:0];
    emit    = !is_ctrl || (op == asd_pkg::OpRepeat);

    step  = asd_pkg::step_lookup(cur_idx);
    delta = (shift_q[7:4] == 4'd0) ? asd_pkg::DeltaW'(step >> shift_q[3:0]) : '0;
    if (in_code_q[0]) delta = delta + asd_pkg::DeltaW'(step);
    if (in_code_q[1]) delta = delta + asd_pkg::DeltaW'(step >> 1);
    if (in_code_q[2]) delta = delta + asd_pkg::DeltaW'(step >> 2);
    if (in_code_q[3]) delta = delta + asd_pkg::DeltaW'(step >> 3);
    if (in_code_q[4]) delta = delta + asd_pkg::DeltaW'(step >> 4);
    if (in_code_q[5]) delta = delta + asd_pkg::DeltaW'(step >> 5);

    // saturate only in the direction of the move
    if (in_code_q[6]) begin
      psum = (asd_pkg::DeltaW+1)'(cur_pred) - $signed({1'b0, delta});
      new_pred = (psum < (asd_pkg::DeltaW+1)'(asd_pkg::SampleMin)) ?
                 asd_pkg::SampleMin : psum[asd_pkg::SampleW-1:0];
    end else begin
      psum = (asd_pkg::DeltaW+1)'(cur_pred) + $signed({1'b0, delta});
      new_pred = (psum > (asd_pkg::DeltaW+1)'(asd_pkg::SampleMax)) ?
                 asd_pkg::SampleMax : psum[asd_pkg::SampleW-1:0];
    end

    adj = asd_pkg::index_adjust(in_code_q[4:0]);
    if (!is_ctrl) begin
      idx_sum = $signed({2'b00, cur_idx}) + $signed({{4{adj[4]}}, adj});
    end else if (op == asd_pkg::OpRepeat) begin
      idx_sum = $signed({2'b00, cur_idx}) - 9'sd1;
    end else if (op == asd_pkg::OpRaise) begin
      idx_sum = $signed({2'b00, cur_idx}) + 9'sd8;
    end else begin
      idx_sum = $signed({2'b00, cur_idx}) - 9'sd8;
    end
    if (idx_sum < 9'sd0) begin
      new_idx = '0;
    end else if (idx_sum > $signed({2'b00, asd_pkg::IdxMax})) begin
      new_idx = asd_pkg::IdxMax;
    end else begin
      new_idx = idx_sum[asd_pkg::IdxW-1:0];
    end

    res_smp = is_ctrl ? cur_pred : new_pred;

    for (int c = 0; c < 2; c++) begin
      idx_d[c]  = eff_idx[c];
      pred_d[c] = eff_pred[c];
    end
    idx_d[ch] = new_idx;
    if (!is_ctrl) pred_d[ch] = new_pred;
    // silent control codes keep the channel
    chan_d = emit ? ch : eff_chan;
  end

  // hold the byte while a sample is stalled; silent codes pass regardless
  assign advance       = in_vld_q && (!emit || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q[0]  <= asd_pkg::IdxReset;
      idx_q[1]  <= asd_pkg::IdxReset;
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      chan_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        idx_q[0]  <= idx_d[0];
        idx_q[1]  <= idx_d[1];
        pred_q[0] <= pred_d[0];
        pred_q[1] <= pred_d[1];
        chan_q    <= chan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_code_q <= s_axis_tdata;
      in_sos_q  <= s_axis_tuser;
    end
    if (advance && emit) begin
      out_smp_q <= res_smp;
      out_ch_q  <= ch;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_smp_q;
  assign m_axis_tuser  = out_ch_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q[0] <= asd_pkg::IdxMax && idx_q[1] <= asd_pkg::IdxMax)
    else $error("step index out of range");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |-> !s_axis_tready)
    else $error("input taken while byte is held");

  a_silent_no_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !emit && (!out_vld_q || m_axis_tready) |=> !m_axis_tvalid)
    else $error("silent control code produced a sample");

  a_mono_reload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && in_sos_q && !stereo_q |=> !m_axis_tuser)
    else $error("mono reload did not decode on channel zero");

  a_stereo_reload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && in_sos_q && stereo_q |=> !m_axis_tuser)
    else $error("stereo reload did not start on channel zero");
`endif

endmodule
